// ===== sv/ght_pkg.sv =====
`timescale 1ns / 1ps
package ght_pkg;

    localparam int COORD_W = 32;
    localparam int IDX_W   = 16;
    localparam int RAD_W   = 31;
    localparam int CFG_W   = 32;
    localparam int REG_W   = 2;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int MUL_W   = DIFF_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int LIMB_W  = DIFF_W;
    localparam int LEN_W   = 2 * DIFF_W;
    localparam int R2_W    = 2 * RAD_W;
    localparam int WIDE_W  = 2 * LEN_W + 2;

    localparam logic [1:0] RING_FULL = 2'd3;

    localparam logic [REG_W-1:0] REG_QUERY_X    = 2'd0;
    localparam logic [REG_W-1:0] REG_QUERY_Y    = 2'd1;
    localparam logic [REG_W-1:0] REG_HIT_RADIUS = 2'd2;

    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_LINE   = 2'd1;
    localparam logic [1:0] MODE_REGION = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic [RAD_W-1:0]          rad;
    } t_cfg;

    function automatic logic signed [DIFF_W-1:0] diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

// ===== sv/ght_ifs.sv =====
`timescale 1ns / 1ps
interface ght_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       mode;
    logic signed [ght_pkg::COORD_W-1:0] vx;
    logic signed [ght_pkg::COORD_W-1:0] vy;
    logic                             ring_start;
    logic                             ring_end;
    logic                             is_hole;
    logic                             geometry_end;
    modport source (output valid, mode, vx, vy, ring_start, ring_end, is_hole, geometry_end,
                    input ready);
    modport sink (input valid, mode, vx, vy, ring_start, ring_end, is_hole, geometry_end,
                  output ready);
endinterface

interface ght_out_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [ght_pkg::IDX_W-1:0] geometry_index;
    modport source (output valid, hit, geometry_index, input ready);
    modport sink (input valid, hit, geometry_index, output ready);
endinterface

interface ght_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ght_pkg::REG_W-1:0] index;
    logic [ght_pkg::CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ght_cfg.sv =====
`timescale 1ns / 1ps
module ght_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ght_cfg_if.sink        i_cfg,
    output ght_pkg::t_cfg  o_cfg
);

    ght_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ght_pkg::REG_QUERY_X:    r_cfg.qx  <= $signed(i_cfg.data);
                ght_pkg::REG_QUERY_Y:    r_cfg.qy  <= $signed(i_cfg.data);
                ght_pkg::REG_HIT_RADIUS: r_cfg.rad <= i_cfg.data[ght_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/ght_mul.sv =====
`timescale 1ns / 1ps
module ght_mul (
    input  logic signed [ght_pkg::MUL_W-1:0]  i_a,
    input  logic signed [ght_pkg::MUL_W-1:0]  i_b,
    output logic signed [ght_pkg::PROD_W-1:0] o_p
);

    function automatic logic signed [ght_pkg::PROD_W-1:0] PROD_W_EXT(
        input logic signed [ght_pkg::MUL_W-1:0] v
    );
        return ght_pkg::PROD_W'(v);
    endfunction

    assign o_p = PROD_W_EXT(i_a) * PROD_W_EXT(i_b);

endmodule

// ===== sv/ght_core.sv =====
`timescale 1ns / 1ps
module ght_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ght_pkg::t_cfg i_cfg,
    ght_in_if.sink        i_in,
    ght_out_if.source     o_out
);

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_SQ0  = 16'b0000_0000_0000_0010,
        S_SQ1  = 16'b0000_0000_0000_0100,
        S_NEAR = 16'b0000_0000_0000_1000,
        S_DOT0 = 16'b0000_0000_0001_0000,
        S_DOT1 = 16'b0000_0000_0010_0000,
        S_PICK = 16'b0000_0000_0100_0000,
        S_CRS0 = 16'b0000_0000_1000_0000,
        S_CRS1 = 16'b0000_0001_0000_0000,
        S_MAG  = 16'b0000_0010_0000_0000,
        S_WIDE = 16'b0000_0100_0000_0000,
        S_WCHK = 16'b0000_1000_0000_0000,
        S_EDG0 = 16'b0001_0000_0000_0000,
        S_EDG1 = 16'b0010_0000_0000_0000,
        S_EDGC = 16'b0100_0000_0000_0000,
        S_DONE = 16'b1000_0000_0000_0000
    } t_state;

    localparam int CW = ght_pkg::COORD_W;
    localparam int DW = ght_pkg::DIFF_W;
    localparam int MW = ght_pkg::MUL_W;
    localparam int PW = ght_pkg::PROD_W;
    localparam int LW = ght_pkg::LIMB_W;
    localparam int NW = ght_pkg::LEN_W;
    localparam int RW = ght_pkg::R2_W;
    localparam int WW = ght_pkg::WIDE_W;
    localparam logic [2:0] WIDE_LAST = 3'd6;
    localparam logic [1:0] RING_FULL_C = ght_pkg::RING_FULL;

    t_state r_state, n_state;

    // geometry state
    logic signed [CW-1:0] r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic [1:0]           r_cnt;
    logic                 r_parity, r_inside, r_in_hole, r_ghit, r_is_hole;
    logic [ght_pkg::IDX_W-1:0] r_gcnt;

    // current word
    logic signed [CW-1:0] r_x, r_y;
    logic [1:0]           r_mode;
    logic                 r_ge, r_do_close, r_edge_two, r_seg, r_eok, r_edir;

    // shared datapath
    logic signed [DW-1:0] r_ux, r_uy, r_wx, r_wy;
    logic signed [PW-1:0] r_acc;
    logic [NW-1:0]        r_len2, r_cm;
    logic [RW-1:0]        r_r2;
    logic signed [WW-1:0] r_wd;
    logic [2:0]           r_k;

    logic                 r_o_valid, r_o_hit;
    logic [ght_pkg::IDX_W-1:0] r_o_idx;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_p;
    logic                 w_acc_in, w_first, w_out_free, w_close_in, w_cross;
    logic [1:0]           w_cnt_new;
    logic signed [WW-1:0] w_term, w_base;
    logic [7:0]           w_sh;
    logic                 w_wsub, w_inside_n, w_hole_n, w_ghit_n;

    ght_mul u_mul (.i_a(w_ma), .i_b(w_mb), .o_p(w_p));

    assign i_in.ready   = (r_state == S_IDLE);
    assign w_acc_in     = i_in.valid && i_in.ready;
    assign w_out_free   = !r_o_valid || o_out.ready;
    assign o_out.valid  = r_o_valid;
    assign o_out.hit    = r_o_hit;
    assign o_out.geometry_index = r_o_idx;

    assign w_first   = i_in.ring_start || (r_cnt == 2'd0);
    assign w_cnt_new = w_first ? 2'd1 : ((r_cnt == RING_FULL_C) ? RING_FULL_C : r_cnt + 2'd1);
    assign w_close_in = (i_in.mode == ght_pkg::MODE_REGION) &&
                        (i_in.ring_end || i_in.geometry_end) && (w_cnt_new == RING_FULL_C);

    // edge test outcome from lhs - rhs held in the accumulator
    assign w_cross = r_eok && (r_edir ? r_acc[PW-1] : (!r_acc[PW-1] && (r_acc != '0)));

    // multiplier operand selection
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_IDLE: begin
                w_ma = $signed(MW'(i_cfg.rad));
                w_mb = $signed(MW'(i_cfg.rad));
            end
            S_SQ0:  begin w_ma = MW'(r_ux); w_mb = MW'(r_ux); end
            S_SQ1:  begin w_ma = MW'(r_uy); w_mb = MW'(r_uy); end
            S_DOT0: begin w_ma = MW'(r_wx); w_mb = MW'(r_ux); end
            S_DOT1: begin w_ma = MW'(r_wy); w_mb = MW'(r_uy); end
            S_CRS0: begin w_ma = MW'(r_ux); w_mb = MW'(r_wy); end
            S_CRS1: begin w_ma = MW'(r_uy); w_mb = MW'(r_wx); end
            S_EDG0: begin w_ma = MW'(r_ux); w_mb = MW'(r_uy); end
            S_EDG1: begin w_ma = MW'(r_wx); w_mb = MW'(r_wy); end
            S_WIDE: begin
                unique case (r_k)
                    3'd0: begin
                        w_ma = $signed(MW'(r_r2[LW-1:0]));
                        w_mb = $signed(MW'(r_len2[LW-1:0]));
                    end
                    3'd1: begin
                        w_ma = $signed(MW'(r_r2[LW-1:0]));
                        w_mb = $signed(MW'(r_len2[NW-1:LW]));
                    end
                    3'd2: begin
                        w_ma = $signed(MW'(r_r2[RW-1:LW]));
                        w_mb = $signed(MW'(r_len2[LW-1:0]));
                    end
                    3'd3: begin
                        w_ma = $signed(MW'(r_r2[RW-1:LW]));
                        w_mb = $signed(MW'(r_len2[NW-1:LW]));
                    end
                    3'd4: begin
                        w_ma = $signed(MW'(r_cm[LW-1:0]));
                        w_mb = $signed(MW'(r_cm[LW-1:0]));
                    end
                    3'd5: begin
                        w_ma = $signed(MW'(r_cm[LW-1:0]));
                        w_mb = $signed(MW'(r_cm[NW-1:LW]));
                    end
                    3'd6: begin
                        w_ma = $signed(MW'(r_cm[NW-1:LW]));
                        w_mb = $signed(MW'(r_cm[NW-1:LW]));
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // wide accumulation of r2 * len2 - cross^2 over limb products
    always_comb begin
        unique case (r_k)
            3'd1, 3'd2: w_sh = 8'(LW);
            3'd3, 3'd6: w_sh = 8'(2 * LW);
            3'd5:       w_sh = 8'(LW + 1);
            default:    w_sh = 8'd0;
        endcase
        w_wsub = (r_k >= 3'd4);
        w_term = WW'(w_p) <<< w_sh;
        w_base = (r_k == 3'd0) ? '0 : r_wd;
    end

    // ring close and part close at the end of the word
    always_comb begin
        w_inside_n = r_inside;
        w_hole_n   = r_in_hole;
        if (r_do_close) begin
            if (r_is_hole) begin
                if (r_parity) w_hole_n = 1'b1;
            end else begin
                w_inside_n = r_parity;
            end
        end
        w_ghit_n = r_ghit;
        if (r_mode == ght_pkg::MODE_REGION && w_inside_n && !w_hole_n) w_ghit_n = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    priority if (i_in.mode == ght_pkg::MODE_POINT) n_state = S_SQ0;
                    else if (i_in.mode == ght_pkg::MODE_LINE && !w_first) n_state = S_SQ0;
                    else if (i_in.mode == ght_pkg::MODE_REGION && !w_first) n_state = S_EDG0;
                    else n_state = S_DONE;
                end
            end
            S_SQ0:  n_state = S_SQ1;
            S_SQ1:  n_state = r_seg ? S_DOT0 : S_NEAR;
            S_NEAR: n_state = S_DONE;
            S_DOT0: n_state = S_DOT1;
            S_DOT1: n_state = S_PICK;
            S_PICK: begin
                priority if (r_len2 == '0 || r_acc[PW-1] || r_acc == '0) n_state = S_SQ0;
                else if (r_acc >= $signed(PW'(r_len2))) n_state = S_SQ0;
                else n_state = S_CRS0;
            end
            S_CRS0: n_state = S_CRS1;
            S_CRS1: n_state = S_MAG;
            S_MAG:  n_state = S_WIDE;
            S_WIDE: n_state = (r_k == WIDE_LAST) ? S_WCHK : S_WIDE;
            S_WCHK: n_state = S_DONE;
            S_EDG0: n_state = S_EDG1;
            S_EDG1: n_state = S_EDGC;
            S_EDGC: n_state = (r_do_close && !r_edge_two) ? S_EDG0 : S_DONE;
            S_DONE: n_state = (!r_ge || w_out_free) ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_cnt      <= '0;
            r_parity   <= 1'b0;
            r_inside   <= 1'b0;
            r_in_hole  <= 1'b0;
            r_ghit     <= 1'b0;
            r_is_hole  <= 1'b0;
            r_gcnt     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_o_valid <= (r_state == S_DONE && r_ge && w_out_free) ||
                         (r_o_valid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    r_r2 <= w_p[RW-1:0];
                    if (w_acc_in) begin
                        r_x        <= i_in.vx;
                        r_y        <= i_in.vy;
                        r_mode     <= i_in.mode;
                        r_ge       <= i_in.geometry_end;
                        r_do_close <= w_close_in;
                        r_edge_two <= 1'b0;
                        r_prev_x   <= i_in.vx;
                        r_prev_y   <= i_in.vy;
                        r_cnt      <= (i_in.ring_end || i_in.geometry_end) ? 2'd0 : w_cnt_new;
                        if (i_in.mode == ght_pkg::MODE_REGION && w_first) begin
                            r_first_x <= i_in.vx;
                            r_first_y <= i_in.vy;
                            r_parity  <= 1'b0;
                            r_is_hole <= i_in.is_hole;
                            if (!i_in.is_hole) begin
                                if (r_inside && !r_in_hole) r_ghit <= 1'b1;
                                r_inside  <= 1'b0;
                                r_in_hole <= 1'b0;
                            end
                        end
                        priority if (i_in.mode == ght_pkg::MODE_POINT) begin
                            r_seg <= 1'b0;
                            r_ux  <= ght_pkg::diff(i_in.vx, i_cfg.qx);
                            r_uy  <= ght_pkg::diff(i_in.vy, i_cfg.qy);
                        end else if (i_in.mode == ght_pkg::MODE_LINE) begin
                            r_seg <= 1'b1;
                            r_ux  <= ght_pkg::diff(i_in.vx, r_prev_x);
                            r_uy  <= ght_pkg::diff(i_in.vy, r_prev_y);
                            r_wx  <= ght_pkg::diff(i_cfg.qx, r_prev_x);
                            r_wy  <= ght_pkg::diff(i_cfg.qy, r_prev_y);
                        end else begin
                            // edge from this vertex back to the previous one
                            r_ux   <= ght_pkg::diff(i_cfg.qx, i_in.vx);
                            r_uy   <= ght_pkg::diff(r_prev_y, i_in.vy);
                            r_wx   <= ght_pkg::diff(r_prev_x, i_in.vx);
                            r_wy   <= ght_pkg::diff(i_cfg.qy, i_in.vy);
                            r_eok  <= (i_in.vy > i_cfg.qy) != (r_prev_y > i_cfg.qy);
                            r_edir <= r_prev_y > i_in.vy;
                        end
                    end
                end
                S_SQ0:  r_acc <= w_p;
                S_SQ1:  r_acc <= r_acc + w_p;
                S_NEAR: begin
                    if (r_acc[NW-1:0] <= NW'(r_r2)) r_ghit <= 1'b1;
                end
                S_DOT0: begin
                    r_len2 <= r_acc[NW-1:0];
                    r_acc  <= w_p;
                end
                S_DOT1: r_acc <= r_acc + w_p;
                S_PICK: begin
                    r_seg <= 1'b0;
                    priority if (r_len2 == '0 || r_acc[PW-1] || r_acc == '0) begin
                        r_ux <= r_wx;
                        r_uy <= r_wy;
                    end else if (r_acc >= $signed(PW'(r_len2))) begin
                        r_ux <= ght_pkg::diff(i_cfg.qx, r_x);
                        r_uy <= ght_pkg::diff(i_cfg.qy, r_y);
                    end else begin
                        r_k <= 3'd0;
                    end
                end
                S_CRS0: r_acc <= w_p;
                S_CRS1: r_acc <= r_acc - w_p;
                S_MAG:  r_cm <= r_acc[PW-1] ? NW'(-r_acc) : r_acc[NW-1:0];
                S_WIDE: begin
                    r_wd <= w_wsub ? w_base - w_term : w_base + w_term;
                    r_k  <= r_k + 3'd1;
                end
                S_WCHK: begin
                    if (!r_wd[WW-1]) r_ghit <= 1'b1;
                end
                S_EDG0: r_acc <= w_p;
                S_EDG1: r_acc <= r_acc - w_p;
                S_EDGC: begin
                    if (w_cross) r_parity <= !r_parity;
                    if (r_do_close && !r_edge_two) begin
                        // closing edge from the ring's first vertex to this one
                        r_edge_two <= 1'b1;
                        r_ux   <= ght_pkg::diff(i_cfg.qx, r_first_x);
                        r_uy   <= ght_pkg::diff(r_y, r_first_y);
                        r_wx   <= ght_pkg::diff(r_x, r_first_x);
                        r_wy   <= ght_pkg::diff(i_cfg.qy, r_first_y);
                        r_eok  <= (r_first_y > i_cfg.qy) != (r_y > i_cfg.qy);
                        r_edir <= r_y > r_first_y;
                    end
                end
                S_DONE: begin
                    if (!r_ge) begin
                        r_inside  <= w_inside_n;
                        r_in_hole <= w_hole_n;
                    end else if (w_out_free) begin
                        r_o_hit   <= w_ghit_n;
                        r_o_idx   <= r_gcnt;
                        r_gcnt    <= r_gcnt + 1'b1;
                        r_ghit    <= 1'b0;
                        r_inside  <= 1'b0;
                        r_in_hole <= 1'b0;
                        r_parity  <= 1'b0;
                        r_is_hole <= 1'b0;
                        r_cnt     <= '0;
                        r_prev_x  <= '0;
                        r_prev_y  <= '0;
                        r_first_x <= '0;
                        r_first_y <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/geometry_hit_test_unit.sv =====
`timescale 1ns / 1ps
// Pick test of a query point against a stream of geometries, one vertex word
// at a time; a word flagged geometry_end yields one result word with the hit
// flag and the running geometry index. All tests are exact compares of
// squared or cross-multiplied products on one shared 35x35 signed multiplier
// under a small sequencer, and the input is not ready while a word is being
// worked on. A vertex with no arithmetic goes straight to done, a point-set
// vertex squares its distance, a region edge runs an edge test (again for the
// closing edge of a closing ring), a polyline segment a dot product and then
// an end-point distance or the perpendicular test (seven limb products
// accumulate r^2*len^2 - cross^2). The user must write query and radius
// through the configuration channel only while idle; the block won't check.
module geometry_hit_test_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ght_in_if.sink    i_in,
    ght_out_if.source o_out,
    ght_cfg_if.sink   i_cfg
);

    ght_pkg::t_cfg w_cfg;

    ght_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ght_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
